>>> hw/rtl/sndva_pkg.sv
package sndva_pkg;

	localparam int TIME_W   = 32;
	localparam int CNT_W    = 27;
	localparam int CH_W     = 5;
	localparam int HANDLE_W = 32;

	localparam logic [TIME_W-1:0] END_FOREVER = '1;

	typedef enum logic [1:0] {
		KIND_PLAY_SOUND = 2'd0,
		KIND_PLAY_MUSIC = 2'd1,
		KIND_STOP_SOUND = 2'd2,
		KIND_STOP_MUSIC = 2'd3
	} kind_t;

	typedef struct packed {
		logic                ok;
		logic [CH_W-1:0]     channel;
		logic [HANDLE_W-1:0] handle_out;
		logic                key_on;
		logic                key_off;
	} rsp_t;

endpackage

>>> hw/rtl/sndva_req_if.sv
interface sndva_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic [sndva_pkg::TIME_W-1:0]   now;
	logic [sndva_pkg::TIME_W-1:0]   sound_length;
	logic                          looping;
	logic [sndva_pkg::HANDLE_W-1:0] handle_in;

	modport source (output valid, kind, now, sound_length, looping, handle_in, input ready);
	modport sink   (input valid, kind, now, sound_length, looping, handle_in, output ready);
endinterface

>>> hw/rtl/sndva_rsp_if.sv
interface sndva_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          ok;
	logic [sndva_pkg::CH_W-1:0]     channel;
	logic [sndva_pkg::HANDLE_W-1:0] handle_out;
	logic                          key_on;
	logic                          key_off;

	modport source (output valid, ok, channel, handle_out, key_on, key_off, input ready);
	modport sink   (input valid, ok, channel, handle_out, key_on, key_off, output ready);
endinterface

>>> hw/rtl/sndva_ram.sv
module sndva_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 24
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/sound_voice_allocator.sv
// Voice allocator: hands out sound voices and stops them by generation handle.
// Request channel (req): kind, now, sound_length, looping, handle_in. One
// response per request on the rsp channel: ok, channel, handle_out, key_on,
// key_off. A request is taken only while the block is idle; one is worked on
// at a time.
// Scan: a sound play scans voices 0 .. CHANNELS-2 through the end-time and
// counter memories at one read per cycle, stopping at the first free voice;
// the response goes to a result register and then to the output register.
// Music play and the stops take one memory read each.
// The block goes idle as the output register loads and takes a new request
// the cycle after, so it never takes a new request before the last response
// is in the output register. The voice scan through the memory read port
// sets the pace of a back-to-back stream of sound plays.
// The output register holds a finished response while rsp.ready is low; the
// block takes the next request meanwhile and parks its result until the
// register frees up.
// Reset: every end time and play counter reads as zero (per-entry valid flags
// are cleared), the output register is emptied and the block is idle at once.
module sound_voice_allocator #(
	parameter int CHANNELS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	sndva_req_if.sink   req,
	sndva_rsp_if.source rsp
);
	import sndva_pkg::*;

	localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ENTRIES = 1 << CW;
	localparam logic [CW-1:0]   MUSIC    = CW'(CHANNELS - 1);
	localparam logic [CH_W:0]   CH_LIMIT = (CH_W + 1)'(CHANNELS);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_CHECK, ST_DONE} state_t;

	state_t              state_q;
	kind_t               kind_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   start_end_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [CW-1:0]       addr_q;
	logic [CW-1:0]       addr_s1;
	logic                rd_s1;
	rsp_t                res_q;
	rsp_t                out_q;
	logic                out_valid_q;
	logic [ENTRIES-1:0]  end_vld_q;
	logic [ENTRIES-1:0]  cnt_vld_q;

	logic [CW-1:0]       raddr;
	logic [CW-1:0]       waddr;
	logic                end_we;
	logic [TIME_W-1:0]   end_wdata;
	logic [TIME_W-1:0]   end_rdata;
	logic                cnt_we;
	logic [CNT_W-1:0]    cnt_wdata;
	logic [CNT_W-1:0]    cnt_rdata;

	logic [TIME_W-1:0]   end_rd;
	logic [CNT_W-1:0]    cnt_rd;
	logic [CNT_W-1:0]    cnt_next;
	logic                free;
	logic                hit;
	logic                issuing;
	logic                ch_ok;
	logic                cnt_match;
	logic [TIME_W:0]     sum;
	logic [TIME_W-1:0]   start_end;
	rsp_t                res_d;
	logic                accept;
	logic                out_free;

	sndva_ram #(.WIDTH(TIME_W), .DEPTH(CHANNELS)) u_end_ram (
		.clk   (clk),
		.we    (end_we),
		.waddr (waddr),
		.wdata (end_wdata),
		.raddr (raddr),
		.rdata (end_rdata)
	);

	sndva_ram #(.WIDTH(CNT_W), .DEPTH(CHANNELS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (waddr),
		.wdata (cnt_wdata),
		.raddr (raddr),
		.rdata (cnt_rdata)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// end time for a play, saturating; a looping play never ends
	assign sum       = {1'b0, req.now} + {1'b0, req.sound_length};
	assign start_end = (req.looping || sum[TIME_W]) ? END_FOREVER : sum[TIME_W-1:0];

	// never-written entries read as zero
	assign end_rd    = end_vld_q[addr_s1] ? end_rdata : '0;
	assign cnt_rd    = cnt_vld_q[addr_s1] ? cnt_rdata : '0;
	assign cnt_next  = cnt_rd + CNT_W'(1);
	assign free      = end_rd < now_q;
	assign hit       = rd_s1 && free;
	assign issuing   = addr_q < MUSIC;
	assign ch_ok     = {1'b0, handle_q[CH_W-1:0]} < CH_LIMIT;
	assign cnt_match = cnt_rd == handle_q[HANDLE_W-1:CH_W];

	always_comb begin
		raddr = addr_q;
		if (state_q == ST_IDLE) begin
			case (kind_t'(req.kind))
				KIND_STOP_SOUND: raddr = req.handle_in[CW-1:0];
				KIND_STOP_MUSIC: raddr = MUSIC;
				KIND_PLAY_MUSIC: raddr = MUSIC;
				default:         raddr = '0;
			endcase
		end
	end

	always_comb begin
		end_we    = 1'b0;
		end_wdata = '0;
		cnt_we    = 1'b0;
		cnt_wdata = cnt_next;
		waddr     = addr_s1;
		res_d     = '0;
		case (state_q)
			ST_SCAN: begin
				if (hit) begin
					end_we           = 1'b1;
					end_wdata        = start_end_q;
					cnt_we           = 1'b1;
					res_d.ok         = 1'b1;
					res_d.channel    = CH_W'(addr_s1);
					res_d.handle_out = {cnt_next, CH_W'(addr_s1)};
					res_d.key_on     = 1'b1;
				end
			end
			ST_CHECK: begin
				case (kind_q)
					KIND_PLAY_MUSIC: begin
						end_we        = 1'b1;
						end_wdata     = start_end_q;
						waddr         = MUSIC;
						res_d.ok      = 1'b1;
						res_d.channel = CH_W'(MUSIC);
						res_d.key_on  = 1'b1;
					end
					KIND_STOP_SOUND: begin
						if (ch_ok && cnt_match) begin
							end_we        = 1'b1;
							res_d.ok      = 1'b1;
							res_d.channel = CH_W'(addr_s1);
							res_d.key_off = 1'b1;
						end
					end
					KIND_STOP_MUSIC: begin
						if (end_rd != '0) begin
							end_we        = 1'b1;
							res_d.ok      = 1'b1;
							res_d.channel = CH_W'(MUSIC);
							res_d.key_off = 1'b1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_vld_q <= '0;
			cnt_vld_q <= '0;
		end else begin
			if (end_we) begin
				end_vld_q[waddr] <= 1'b1;
			end
			if (cnt_we) begin
				cnt_vld_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_PLAY_SOUND;
			now_q       <= '0;
			start_end_q <= '0;
			handle_q    <= '0;
			addr_q      <= '0;
			addr_s1     <= '0;
			rd_s1       <= 1'b0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q      <= kind_t'(req.kind);
						now_q       <= req.now;
						start_end_q <= start_end;
						handle_q    <= req.handle_in;
						addr_s1     <= raddr;
						addr_q      <= CW'(1);
						if (kind_t'(req.kind) == KIND_PLAY_SOUND) begin
							rd_s1   <= 1'b1;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_SCAN: begin
					// one read issued per cycle, its data checked in the next cycle
					rd_s1   <= issuing && !hit;
					addr_s1 <= addr_q;
					if (issuing) begin
						addr_q <= addr_q + CW'(1);
					end
					if (hit || !issuing) begin
						res_q   <= res_d;
						state_q <= ST_DONE;
					end
				end
				ST_CHECK: begin
					res_q   <= res_d;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.ok         = out_q.ok;
	assign rsp.channel    = out_q.channel;
	assign rsp.handle_out = out_q.handle_out;
	assign rsp.key_on     = out_q.key_on;
	assign rsp.key_off    = out_q.key_off;

	a_key_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.key_on && rsp.key_off))
		else $error("key_on and key_off together");

	a_handle_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.handle_out != '0) |-> (rsp.ok && rsp.key_on))
		else $error("handle returned without a grant");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> (state_q == ST_SCAN))
		else $error("scan read pending outside scan");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		(end_we || cnt_we) |-> (state_q == ST_SCAN || state_q == ST_CHECK))
		else $error("memory write outside update states");

	a_done_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished result not moved to output");
endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import sndva_pkg::*;

	localparam int CHANNELS       = 24;
	localparam int MUSIC_VOICE    = CHANNELS - 1;
	localparam int RANDOM_ITEMS   = 850;
	localparam int HOLD_AT_RSP    = 300;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		kind_t               kind;
		logic [TIME_W-1:0]   now;
		logic [TIME_W-1:0]   sound_length;
		logic                looping;
		logic [HANDLE_W-1:0] handle_in;
	} voice_req_t;

	logic clk;
	logic arst_n;

	sndva_req_if req_ch ();
	sndva_rsp_if rsp_ch ();

	sound_voice_allocator #(.CHANNELS(CHANNELS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predicted voice state
	logic [TIME_W-1:0] voice_end [CHANNELS];
	logic [CNT_W-1:0]  voice_gen [CHANNELS];

	voice_req_t pending_req[$];
	rsp_t       expected_rsp[$];
	voice_req_t in_flight;

	int  errors;
	int  rsp_count;
	int  idle_cycles;
	int  gap_left;
	int  stall_left;
	bit  burst_mode;
	int  n_granted, n_no_voice, n_music, n_stop_hit, n_stop_miss;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.kind         = KIND_PLAY_SOUND;
		req_ch.now          = '0;
		req_ch.sound_length = '0;
		req_ch.looping      = 1'b0;
		req_ch.handle_in    = '0;
		rsp_ch.ready        = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int pick_gap();
		int r;
		if (burst_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [TIME_W-1:0] play_end(voice_req_t r);
		logic [TIME_W:0] sum;
		if (r.looping)
			return END_FOREVER;
		sum = {1'b0, r.now} + {1'b0, r.sound_length};
		return sum[TIME_W] ? END_FOREVER : sum[TIME_W-1:0];
	endfunction

	// applies one request to the voice state and returns its response
	function automatic rsp_t allocate_voice(voice_req_t r);
		rsp_t res;
		int   ch;
		bit   found;
		res   = '0;
		found = 1'b0;
		case (r.kind)
			KIND_PLAY_SOUND: begin
				for (int c = 0; c < MUSIC_VOICE; c++) begin
					if (!found && voice_end[c] < r.now) begin
						found          = 1'b1;
						voice_gen[c]   = voice_gen[c] + CNT_W'(1);
						voice_end[c]   = play_end(r);
						res.ok         = 1'b1;
						res.channel    = CH_W'(c);
						res.handle_out = {voice_gen[c], CH_W'(c)};
						res.key_on     = 1'b1;
					end
				end
			end
			KIND_PLAY_MUSIC: begin
				voice_end[MUSIC_VOICE] = play_end(r);
				res.ok      = 1'b1;
				res.channel = CH_W'(MUSIC_VOICE);
				res.key_on  = 1'b1;
			end
			KIND_STOP_SOUND: begin
				ch = int'(r.handle_in[CH_W-1:0]);
				if (ch < CHANNELS && voice_gen[ch] == r.handle_in[HANDLE_W-1:CH_W]) begin
					voice_end[ch] = '0;
					res.ok        = 1'b1;
					res.channel   = CH_W'(ch);
					res.key_off   = 1'b1;
				end
			end
			default: begin
				if (voice_end[MUSIC_VOICE] != '0) begin
					voice_end[MUSIC_VOICE] = '0;
					res.ok      = 1'b1;
					res.channel = CH_W'(MUSIC_VOICE);
					res.key_off = 1'b1;
				end
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on response %0d, %s: got %0h, want %0h", rsp_count, what, got, want);
		errors++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		rsp_t res;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			gap_left = 0;
			for (int c = 0; c < CHANNELS; c++) begin
				voice_end[c] = '0;
				voice_gen[c] = '0;
			end
		end else if (!(req_ch.valid && !req_ch.ready)) begin
			if (req_ch.valid) begin
				res = allocate_voice(in_flight);
				expected_rsp.push_back(res);
				case (in_flight.kind)
					KIND_PLAY_SOUND: if (res.ok) n_granted++; else n_no_voice++;
					KIND_PLAY_MUSIC: n_music++;
					default:         if (res.ok) n_stop_hit++; else n_stop_miss++;
				endcase
			end
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (pending_req.size() != 0) begin
				in_flight = pending_req.pop_front();
				req_ch.kind         <= in_flight.kind;
				req_ch.now          <= in_flight.now;
				req_ch.sound_length <= in_flight.sound_length;
				req_ch.looping      <= in_flight.looping;
				req_ch.handle_in    <= in_flight.handle_in;
				req_ch.valid        <= 1'b1;
				gap_left = pick_gap();
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// response monitor and back-pressure
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch("transaction with nothing expected", rsp_ch.handle_out, 0);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp_ch.ok !== want.ok)
						report_mismatch("ok", 32'(rsp_ch.ok), 32'(want.ok));
					if (rsp_ch.channel !== want.channel)
						report_mismatch("channel", 32'(rsp_ch.channel), 32'(want.channel));
					if (rsp_ch.handle_out !== want.handle_out)
						report_mismatch("handle_out", rsp_ch.handle_out, want.handle_out);
					if (rsp_ch.key_on !== want.key_on)
						report_mismatch("key_on", 32'(rsp_ch.key_on), 32'(want.key_on));
					if (rsp_ch.key_off !== want.key_off)
						report_mismatch("key_off", 32'(rsp_ch.key_off), 32'(want.key_off));
				end
				rsp_count++;
				// long hold so the block fills up and refuses requests
				if (rsp_count == HOLD_AT_RSP)
					stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!burst_mode && $urandom_range(0, 5) == 0) begin
				stall_left = pick_gap();
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", idle_cycles);
				$display("[sound_voice_allocator] ERROR");
				$finish;
			end
		end
	end

	function automatic voice_req_t mk_req(kind_t kind, logic [31:0] now, logic [31:0] len,
			logic looping, logic [31:0] handle);
		voice_req_t r;
		r.kind         = kind;
		r.now          = now;
		r.sound_length = len;
		r.looping      = looping;
		r.handle_in    = handle;
		return r;
	endfunction

	function automatic logic [31:0] live_handle(int ch);
		return {voice_gen[ch], CH_W'(ch)};
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		while (pending_req.size() != 0 || req_ch.valid || expected_rsp.size() != 0)
			@(negedge clk);
	endtask

	// directed requests run one at a time so handles can be built from live state
	task automatic send_one(voice_req_t r);
		pending_req.push_back(r);
		wait_drained();
	endtask

	function automatic voice_req_t random_req(ref logic [31:0] t);
		voice_req_t r;
		int         sel;
		int         ch;
		t += $urandom_range(0, 'h2000);
		if ($urandom_range(0, 99) < 3)
			t = $urandom();
		r = mk_req(KIND_PLAY_SOUND, t, $urandom_range('h200, 'h6000),
			$urandom_range(0, 99) < 8, $urandom());
		if ($urandom_range(0, 99) < 4)
			r.sound_length = $urandom();
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			r.kind = KIND_PLAY_SOUND;
		end else if (sel < 55) begin
			r.kind = KIND_PLAY_MUSIC;
		end else if (sel < 85) begin
			r.kind = KIND_STOP_SOUND;
			ch = $urandom_range(0, CHANNELS - 1);
			sel = $urandom_range(0, 99);
			if (sel < 70)
				r.handle_in = live_handle(ch);
			else if (sel < 85)
				r.handle_in = {voice_gen[ch] - CNT_W'($urandom_range(1, 3)), CH_W'(ch)};
		end else if (sel < 95) begin
			r.kind = KIND_STOP_MUSIC;
		end else begin
			r = mk_req(kind_t'($urandom_range(0, 3)), $urandom(), $urandom(),
				1'($urandom_range(0, 1)), $urandom());
		end
		return r;
	endfunction

	initial begin
		logic [31:0] t;
		errors      = 0;
		rsp_count   = 0;
		idle_cycles = 0;
		burst_mode  = 1'b0;
		n_granted   = 0;
		n_no_voice  = 0;
		n_music     = 0;
		n_stop_hit  = 0;
		n_stop_miss = 0;
		@(posedge arst_n);

		// silent music stop, then a play with nothing expired yet
		send_one(mk_req(KIND_STOP_MUSIC, 0, 0, 0, 0));
		send_one(mk_req(KIND_PLAY_SOUND, 0, 5, 0, 0));
		send_one(mk_req(KIND_PLAY_SOUND, 1, 0, 0, 0));
		send_one(mk_req(KIND_PLAY_SOUND, 1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF));
		send_one(mk_req(KIND_PLAY_SOUND, 2, 0, 1, 0));
		send_one(mk_req(KIND_PLAY_SOUND, 32'hFFFF_FFFF, 1, 0, 0));
		send_one(mk_req(KIND_PLAY_SOUND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0));
		// music replays while playing, stops only when sounding
		send_one(mk_req(KIND_PLAY_MUSIC, 0, 0, 0, 0));
		send_one(mk_req(KIND_STOP_MUSIC, 0, 0, 0, 0));
		send_one(mk_req(KIND_PLAY_MUSIC, 7, 0, 1, 0));
		send_one(mk_req(KIND_PLAY_MUSIC, 100, 50, 0, 0));
		send_one(mk_req(KIND_STOP_MUSIC, 0, 0, 0, 0));
		// handle checks: stale, live, bad voice, music voice by handle
		send_one(mk_req(KIND_STOP_SOUND, 0, 0, 0, {voice_gen[0] - CNT_W'(1), 5'd0}));
		send_one(mk_req(KIND_STOP_SOUND, 0, 0, 0, live_handle(0)));
		send_one(mk_req(KIND_STOP_SOUND, 0, 0, 0, live_handle(1)));
		send_one(mk_req(KIND_STOP_SOUND, 0, 0, 0, 32'd24));
		send_one(mk_req(KIND_STOP_SOUND, 0, 0, 0, 32'hFFFF_FFFF));
		send_one(mk_req(KIND_STOP_SOUND, 0, 0, 0, live_handle(MUSIC_VOICE)));
		send_one(mk_req(KIND_STOP_SOUND, 0, 0, 0, 32'd0));
		send_one(mk_req(KIND_PLAY_SOUND, 3, 32'h0000_1000, 0, 0));

		t = 32'h10;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			@(negedge clk);
			burst_mode = ((i / 120) % 3) == 1;
			while (pending_req.size() >= 2)
				@(negedge clk);
			pending_req.push_back(random_req(t));
		end
		burst_mode = 1'b0;

		wait_drained();
		repeat (CHANNELS + 8) @(posedge clk);
		if (expected_rsp.size() != 0)
			report_mismatch("responses never arrived", 0, expected_rsp.size());

		$display("covered %0d responses: %0d sound grants, %0d with no voice free, %0d music plays",
			rsp_count, n_granted, n_no_voice, n_music);
		$display("stops: %0d acted, %0d ignored (stale, bad voice or silent)",
			n_stop_hit, n_stop_miss);
		if (errors == 0) begin
			$display("[sound_voice_allocator] OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("[sound_voice_allocator] ERROR");
		end
		$finish;
	end

endmodule
